// File: rtl/core/fms_pkg.sv
package fms_pkg;

  localparam logic [3:0] LOW_SAMPLES = 4'd8;
  localparam logic [3:0] COUNT_MAX   = 4'd15;

  localparam logic [7:0] THRESHOLD_RESET = 8'd130;
  localparam logic [2:0] LEVEL_RESET     = 3'd1;

  localparam logic [1:0] CFG_LOW_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_GROUP_SELECT  = 2'd1;
  localparam logic [1:0] CFG_MEMORY_ENABLE = 2'd2;

  localparam logic OP_POWER_ON = 1'b0;
  localparam logic OP_SAMPLE   = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] low_threshold;
    logic       group_select;
    logic       memory_enable;
  } cfg_t;

  typedef struct packed {
    logic is_sample;
    logic long_off;
    logic is_low;
  } cmd_t;

  function automatic logic [2:0] group_len(input logic g);
    return g ? 3'd5 : 3'd7;
  endfunction

  function automatic logic [2:0] group_level(input logic g, input logic [2:0] pos);
    logic [2:0] lv;
    lv = 3'd0;
    if (!g) begin
      lv = (pos == 3'd7) ? 3'd0 : pos + 3'd1;
    end else begin
      case (pos)
        3'd0:    lv = 3'd1;
        3'd1:    lv = 3'd2;
        3'd2:    lv = 3'd3;
        3'd3:    lv = 3'd5;
        3'd4:    lv = 3'd7;
        default: lv = 3'd0;
      endcase
    end
    return lv;
  endfunction

  function automatic logic [7:0] ramp(input logic [2:0] lv);
    logic [7:0] duty;
    case (lv)
      3'd1:    duty = 8'd1;
      3'd2:    duty = 8'd7;
      3'd3:    duty = 8'd32;
      3'd4:    duty = 8'd63;
      3'd5:    duty = 8'd107;
      3'd6:    duty = 8'd127;
      3'd7:    duty = 8'd255;
      default: duty = 8'd0;
    endcase
    return duty;
  endfunction

endpackage

// File: rtl/core/fms_in_if.sv
interface fms_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic       long_off;
  logic [7:0] voltage;

  modport source(output valid, output operation, output long_off, output voltage,
                 input ready);
  modport sink(input valid, input operation, input long_off, input voltage,
               output ready);
endinterface

// File: rtl/core/fms_out_if.sv
interface fms_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pwm_duty;
  logic       fast_pwm;
  logic [2:0] level;
  logic [2:0] mode_index;
  logic       stepped_down;
  logic       shut_down;

  modport source(output valid, output pwm_duty, output fast_pwm, output level,
                 output mode_index, output stepped_down, output shut_down,
                 input ready);
  modport sink(input valid, input pwm_duty, input fast_pwm, input level,
               input mode_index, input stepped_down, input shut_down,
               output ready);
endinterface

// File: rtl/core/flashlight_mode_stepdown.sv
// Brightness mode controller for an LED driver with low-battery step-down.
// Events arrive as beats on in_ch: a power-on event (with the long off-time
// flag) or a battery voltage sample. Every accepted beat yields exactly one
// result beat on out_ch with the PWM duty, PWM mode, level, mode index and
// step-down status after the event.
// Registers are written through cfg_we, cfg_index and cfg_data: index 0 is
// the low-voltage threshold, 1 the group select, 2 mode memory enable.
// An accepted beat passes through the command queue and the result register
// before it appears on out_ch. While out_ch.ready stays high, one beat per
// cycle is sustained and consecutive events follow each other without a gap.
// A two-entry command queue sits between classification and execution, and
// the result register takes a new result as soon as out_ch accepts the old one.
// When out_ch.ready is low, the result holds, the queue fills, and in_ch.ready
// drops once the queue is full. Reset clears the queue and the result valid,
// restores the default registers and puts the light at the first level of the
// group with mode index zero.
module flashlight_mode_stepdown (
  input  logic        clk,
  input  logic        rst_n,
  fms_in_if.sink      in_ch,
  fms_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  fms_pkg::cfg_t cfg_r;
  logic          push;
  fms_pkg::cmd_t push_cmd;
  logic          q_full;
  logic          pop;
  logic          pop_valid;
  fms_pkg::cmd_t pop_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_threshold <= fms_pkg::THRESHOLD_RESET;
      cfg_r.group_select  <= 1'b0;
      cfg_r.memory_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fms_pkg::CFG_LOW_THRESHOLD: cfg_r.low_threshold <= cfg_data;
        fms_pkg::CFG_GROUP_SELECT:  cfg_r.group_select  <= cfg_data[0];
        fms_pkg::CFG_MEMORY_ENABLE: cfg_r.memory_enable <= cfg_data[0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  fms_front u_front (
    .in_ch         (in_ch),
    .low_threshold (cfg_r.low_threshold),
    .q_full        (q_full),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  fms_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd)
  );

  fms_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (pop_valid),
    .cmd       (pop_cmd),
    .cmd_pop   (pop),
    .out_ch    (out_ch)
  );

endmodule

// File: rtl/core/fms_front.sv
module fms_front (
  fms_in_if.sink        in_ch,
  input  logic [7:0]    low_threshold,
  input  logic          q_full,
  output logic          push,
  output fms_pkg::cmd_t push_cmd
);

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    push_cmd.is_sample = (in_ch.operation == fms_pkg::OP_SAMPLE);
    push_cmd.long_off  = in_ch.long_off;
    push_cmd.is_low    = (in_ch.voltage < low_threshold);
  end

endmodule

// File: rtl/core/fms_queue.sv
module fms_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fms_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output fms_pkg::cmd_t pop_cmd
);

  fms_pkg::cmd_t                       mem_r [fms_pkg::QUEUE_DEPTH];
  logic [fms_pkg::QUEUE_AW-1:0]        wr_ptr_r;
  logic [fms_pkg::QUEUE_AW-1:0]        rd_ptr_r;
  logic [fms_pkg::QUEUE_CW-1:0]        count_r;
  logic [fms_pkg::QUEUE_CW-1:0]        count_nxt;

  assign full      = (count_r == fms_pkg::QUEUE_CW'(fms_pkg::QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// File: rtl/core/fms_back.sv
module fms_back (
  input  logic          clk,
  input  logic          rst_n,
  input  fms_pkg::cfg_t cfg,
  input  logic          cmd_valid,
  input  fms_pkg::cmd_t cmd,
  output logic          cmd_pop,
  fms_out_if.source     out_ch
);

  logic [2:0] mode_pos_r;
  logic [2:0] mode_pos_nxt;
  logic [2:0] level_r;
  logic [2:0] level_nxt;
  logic [3:0] count_r;
  logic [3:0] count_nxt;
  logic       off_r;
  logic       off_nxt;
  logic       stepped;
  logic [2:0] len;
  logic [3:0] pos_adv;
  logic [2:0] pos_sel;
  logic [3:0] count_tmp;
  logic [2:0] lv_out;

  logic       out_valid_r;
  logic [7:0] duty_r;
  logic       fast_r;
  logic [2:0] lv_r;
  logic [2:0] idx_r;
  logic       stepped_r;
  logic       shut_r;

  assign cmd_pop = cmd_valid && (!out_valid_r || out_ch.ready);
  assign len     = fms_pkg::group_len(cfg.group_select);
  assign pos_adv = {1'b0, mode_pos_r} + 4'd1;

  always_comb begin
    mode_pos_nxt = mode_pos_r;
    level_nxt    = level_r;
    count_nxt    = count_r;
    off_nxt      = off_r;
    stepped      = 1'b0;
    pos_sel      = mode_pos_r;
    count_tmp    = count_r;
    if (!cmd.is_sample) begin
      if (!cmd.long_off) begin
        pos_sel = (pos_adv >= {1'b0, len}) ? 3'd0 : pos_adv[2:0];
      end else if (!cfg.memory_enable) begin
        pos_sel = 3'd0;
      end
      if (pos_sel >= len) begin
        pos_sel = 3'd0;
      end
      mode_pos_nxt = pos_sel;
      level_nxt    = fms_pkg::group_level(cfg.group_select, pos_sel);
      count_nxt    = 4'd0;
      off_nxt      = 1'b0;
    end else if (!off_r) begin
      if (cmd.is_low) begin
        if (count_r < fms_pkg::COUNT_MAX) begin
          count_tmp = count_r + 4'd1;
        end
      end else begin
        count_tmp = 4'd0;
      end
      if (count_tmp >= fms_pkg::LOW_SAMPLES) begin
        if (level_r > 3'd1) begin
          level_nxt = level_r - 3'd1;
        end else begin
          level_nxt = 3'd0;
          off_nxt   = 1'b1;
        end
        stepped   = 1'b1;
        count_tmp = 4'd0;
      end
      count_nxt = count_tmp;
    end
    lv_out = off_nxt ? 3'd0 : level_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_pos_r  <= 3'd0;
      level_r     <= fms_pkg::LEVEL_RESET;
      count_r     <= 4'd0;
      off_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_pop) begin
        mode_pos_r  <= mode_pos_nxt;
        level_r     <= level_nxt;
        count_r     <= count_nxt;
        off_r       <= off_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      duty_r    <= fms_pkg::ramp(lv_out);
      fast_r    <= (lv_out > 3'd2);
      lv_r      <= lv_out;
      idx_r     <= mode_pos_nxt;
      stepped_r <= stepped;
      shut_r    <= off_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pwm_duty     = duty_r;
  assign out_ch.fast_pwm     = fast_r;
  assign out_ch.level        = lv_r;
  assign out_ch.mode_index   = idx_r;
  assign out_ch.stepped_down = stepped_r;
  assign out_ch.shut_down    = shut_r;

endmodule
